/* hw/rtl/longest_prefix_route_table_top_defines.svh */
// Assertion macros shared by the route table RTL files.
// Included by lprt_cell and longest_prefix_route_table_top; depends on nothing.
`ifndef LONGEST_PREFIX_ROUTE_TABLE_TOP_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LPRT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("lprt assertion failed");

// Next-cycle implication, checked outside reset.
`define LPRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("lprt assertion failed");

`endif

/* hw/rtl/lprt_pkg.sv */
// Types and constants of the longest prefix route table.
// Used by lprt_cell and longest_prefix_route_table_top; depends on nothing.
package lprt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W = 16;
	localparam int PFX_W = 5;
	localparam int IFC_W = 8;
	localparam logic [PFX_W-1:0] HOST_BITS_MAX = PFX_W'(ADDR_W);
	localparam logic [PFX_W-1:0] HOST_BITS_RST = PFX_W'(14);

	typedef enum logic [1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_SET = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef struct packed {
		logic vld;
		logic [1:0] kind;
		logic [ADDR_W-1:0] addr;
		logic [PFX_W-1:0] plen;
		logic [IFC_W-1:0] iface;
		logic [ADDR_W-1:0] via;
		logic [PFX_W-1:0] h;
		logic [ADDR_W-1:0] fmask;
		logic [CNT_W-1:0] left;
		logic found;
		logic [PFX_W-1:0] best_len;
		logic [IFC_W-1:0] best_iface;
		logic [ADDR_W-1:0] best_via;
		logic [PFX_W-1:0] best_prefix;
		logic slot_found;
		logic placed;
	} token_t;

endpackage

/* hw/rtl/lprt_cell.sv */
// One route table cell: holds a single route and passes the request word on.
// Depends on lprt_pkg and longest_prefix_route_table_top_defines.svh.
`include "longest_prefix_route_table_top_defines.svh"

module lprt_cell (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input lprt_pkg::token_t tok_in,
	output lprt_pkg::token_t tok_out
);
	import lprt_pkg::*;

	logic [ADDR_W-1:0] e_addr_q;
	logic [PFX_W-1:0] e_prefix_q;
	logic [IFC_W-1:0] e_iface_q;
	logic [ADDR_W-1:0] e_via_q;
	token_t tok_q;
	token_t tok_nxt;

	logic e_valid;
	logic [PFX_W-1:0] p_eff;
	logic [PFX_W-1:0] shamt;
	logic [ADDR_W-1:0] net_mask;
	logic lk_take;
	logic set_match;
	logic set_append;
	logic wr_en;

	always_comb begin
		e_valid = (tok_in.left != '0);
		p_eff = (e_prefix_q > tok_in.h) ? tok_in.h : e_prefix_q;
		shamt = tok_in.h - p_eff;
		net_mask = tok_in.fmask & ({ADDR_W{1'b1}} << shamt);
		lk_take = (tok_in.kind == KIND_LOOKUP) && e_valid
			&& (((e_addr_q ^ tok_in.addr) & net_mask) == '0)
			&& (!tok_in.found || (p_eff >= tok_in.best_len));
		set_match = (tok_in.kind == KIND_SET) && e_valid && !tok_in.slot_found
			&& (e_addr_q == tok_in.addr) && (e_prefix_q == tok_in.plen);
		set_append = (tok_in.kind == KIND_SET) && !e_valid && !tok_in.slot_found
			&& !tok_in.placed;
		wr_en = adv && tok_in.vld && (set_match || set_append);

		tok_nxt = tok_in;
		tok_nxt.left = e_valid ? (tok_in.left - CNT_W'(1)) : tok_in.left;
		if (lk_take) begin
			tok_nxt.found = 1'b1;
			tok_nxt.best_len = p_eff;
			tok_nxt.best_iface = e_iface_q;
			tok_nxt.best_via = e_via_q;
			tok_nxt.best_prefix = e_prefix_q;
		end
		if (set_match) begin
			tok_nxt.slot_found = 1'b1;
		end
		if (set_append) begin
			tok_nxt.placed = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			e_addr_q <= tok_in.addr;
			e_prefix_q <= tok_in.plen;
			e_iface_q <= tok_in.iface;
			e_via_q <= tok_in.via;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

	`LPRT_ASSERT_NOW(cell_one_write_kind, clk, arst_n, set_match, !set_append)
	`LPRT_ASSERT_NOW(cell_placed_excl, clk, arst_n, tok_q.vld && tok_q.placed,
		!tok_q.slot_found)
	`LPRT_ASSERT_NEXT(cell_hold_on_stall, clk, arst_n, !adv && tok_q.vld,
		tok_q.vld && $stable(tok_q.left) && $stable(tok_q.found))

endmodule

/* hw/rtl/longest_prefix_route_table_top.sv */
// Longest prefix match route table: input register, row of route cells, output register.
// Depends on lprt_pkg, lprt_cell and longest_prefix_route_table_top_defines.svh.
//
// Request words arrive on the s_ channel: s_tuser carries the kind (lookup,
// set or clear) and s_tdata the address, prefix length, interface and next hop.
// Every request gives exactly one response word on the m_ channel: m_tuser is
// the hit flag and m_tdata the interface, next hop, prefix and status.
// User must write host_bits register via cfg_we, cfg_wdata only while idle; unchecked.
// A request walks the row of TABLE_DEPTH cells, one cell per cycle while the row
// advances; each cell holds one route and compares, updates or appends as the word
// passes it. One request is in the row at a time, so a new word is taken only after
// the last one leaves the row; s_tready rises again when the response enters the
// output register. A finished response may wait in the output register while the
// next request walks the row. If the receiver stalls with a response still
// waiting, the row freezes with the next response at its end until the output
// register frees.
// Reset empties the table, sets host_bits to 14 and drops all words in flight.
`include "longest_prefix_route_table_top_defines.svh"

module longest_prefix_route_table_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [4:0] cfg_wdata,
	input logic s_tvalid,
	output logic s_tready,
	// kind[1:0]
	input logic [1:0] s_tuser,
	// address[15:0], prefix_len[20:16], iface_id[28:21], via[44:29], zero fill
	input logic [47:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// hit[0]
	output logic m_tuser,
	// route_iface[7:0], route_via[23:8], route_prefix[28:24], status[29], zero fill
	output logic [31:0] m_tdata
);
	import lprt_pkg::*;

	logic [PFX_W-1:0] host_bits_q;
	logic [CNT_W-1:0] count_q;
	logic busy_q;
	token_t in_tok_q;
	token_t chain [TABLE_DEPTH+1];
	token_t tok_exit;
	logic adv;
	logic acc;
	logic exit_go;
	logic [PFX_W-1:0] h_eff;
	logic [PFX_W-1:0] plen_in;
	logic [PFX_W-1:0] plen_sat;
	logic m_tvalid_q;
	logic m_hit_q;
	logic [31:0] m_data_q;
	logic res_hit;
	logic res_status;

	assign s_tready = !busy_q;
	assign acc = s_tvalid && s_tready;
	assign tok_exit = chain[TABLE_DEPTH];
	assign adv = !(tok_exit.vld && m_tvalid_q && !m_tready);
	assign exit_go = tok_exit.vld && adv;

	assign h_eff = (host_bits_q > HOST_BITS_MAX) ? HOST_BITS_MAX : host_bits_q;
	assign plen_in = s_tdata[20:16];
	assign plen_sat = (plen_in > h_eff) ? h_eff : plen_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_bits_q <= HOST_BITS_RST;
		end else if (cfg_we) begin
			host_bits_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tok_q <= '0;
		end else if (acc) begin
			in_tok_q.vld <= 1'b1;
			in_tok_q.kind <= s_tuser;
			in_tok_q.addr <= s_tdata[15:0];
			in_tok_q.plen <= plen_sat;
			in_tok_q.iface <= s_tdata[28:21];
			in_tok_q.via <= s_tdata[44:29];
			in_tok_q.h <= h_eff;
			in_tok_q.fmask <= ADDR_W'(~({(ADDR_W+1){1'b1}} << h_eff));
			in_tok_q.left <= count_q;
			in_tok_q.found <= 1'b0;
			in_tok_q.best_len <= '0;
			in_tok_q.best_iface <= '0;
			in_tok_q.best_via <= '0;
			in_tok_q.best_prefix <= '0;
			in_tok_q.slot_found <= 1'b0;
			in_tok_q.placed <= 1'b0;
		end else if (adv) begin
			in_tok_q.vld <= 1'b0;
		end
	end

	assign chain[0] = in_tok_q;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		lprt_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.tok_in(chain[i]),
			.tok_out(chain[i+1])
		);
	end

	always_comb begin
		res_hit = (tok_exit.kind == KIND_LOOKUP) && tok_exit.found;
		res_status = (tok_exit.kind == KIND_SET) && !tok_exit.slot_found
			&& !tok_exit.placed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			count_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (acc) begin
				busy_q <= 1'b1;
			end else if (exit_go) begin
				busy_q <= 1'b0;
			end
			if (exit_go) begin
				m_tvalid_q <= 1'b1;
				if (tok_exit.kind == KIND_CLEAR) begin
					count_q <= '0;
				end else if ((tok_exit.kind == KIND_SET) && tok_exit.placed) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exit_go) begin
			m_hit_q <= res_hit;
			m_data_q <= {2'b00, res_status,
				res_hit ? tok_exit.best_prefix : {PFX_W{1'b0}},
				res_hit ? tok_exit.best_via : {ADDR_W{1'b0}},
				res_hit ? tok_exit.best_iface : {IFC_W{1'b0}}};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser = m_hit_q;
	assign m_tdata = m_data_q;

	`LPRT_ASSERT_NOW(top_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(TABLE_DEPTH))
	`LPRT_ASSERT_NEXT(top_busy_after_acc, clk, arst_n, acc, busy_q)
	`LPRT_ASSERT_NOW(top_exit_while_busy, clk, arst_n, tok_exit.vld, busy_q)
	`LPRT_ASSERT_NEXT(top_count_inc, clk, arst_n,
		exit_go && (tok_exit.kind == KIND_SET) && tok_exit.placed,
		count_q == $past(count_q) + CNT_W'(1))

endmodule
